// ===== src/arq_sw_pkg.sv =====
`timescale 1ns / 1ps

package arq_sw_pkg;

  localparam logic OP_ADD = 1'b0;
  localparam logic OP_ACK = 1'b1;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_FULL  = 3'd1,
    ST_BAD   = 3'd2,
    ST_SEQ   = 3'd3,
    ST_NOACK = 3'd4
  } status_t;

  // A search token that moves one cell along the slot chain per cycle.
  typedef struct packed {
    logic       valid;
    logic       claim;
    logic       ack;
    logic [7:0] id;
    logic       found;
    logic [2:0] slot;
    logic [7:0] gap;
  } token_t;

endpackage

// ===== src/arq_sw_cell.sv =====
`timescale 1ns / 1ps

module arq_sw_cell #(
  parameter int IDX = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  arq_sw_pkg::token_t  tok_in,
  input  logic [7:0]          left_edge,
  output arq_sw_pkg::token_t  tok_out,
  output logic                slot_busy
);
  import arq_sw_pkg::*;

  logic [7:0] frame_id;
  logic       hit_claim;
  logic       hit_ack;
  logic       hit;
  logic       live;
  logic [7:0] id_offset;
  logic       slot_busy_next;
  token_t     tok_next;

  always_comb begin
    hit_claim = tok_in.valid && !tok_in.found && tok_in.claim && !slot_busy;
    hit_ack   = tok_in.valid && !tok_in.found && tok_in.ack && slot_busy &&
                (frame_id == tok_in.id);
    hit       = hit_claim || hit_ack;
    live      = slot_busy && !hit;
    id_offset = frame_id - left_edge;

    slot_busy_next = slot_busy;
    if (hit_claim) begin
      slot_busy_next = 1'b1;
    end else if (hit_ack) begin
      slot_busy_next = 1'b0;
    end

    tok_next = tok_in;
    if (hit) begin
      tok_next.found = 1'b1;
      tok_next.slot  = 3'(IDX % 8);
    end
    if (live && (id_offset < tok_in.gap)) begin
      tok_next.gap = id_offset;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_busy <= 1'b0;
      tok_out   <= '0;
    end else begin
      slot_busy <= slot_busy_next;
      tok_out   <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (hit_claim) begin
      frame_id <= tok_in.id;
    end
  end

endmodule

// ===== src/arq_send_window_top.sv =====
`timescale 1ns / 1ps

// Sender window of a selective-repeat ARQ link over 8-bit frame ids.
// A command is transferred at a rising edge where start is high and busy is
// low; operation selects adding a frame or taking an acknowledgment, with
// packet_id and frame_good as its arguments.
// The command then walks a chain of WINDOW_SLOTS slot cells, one cell per
// cycle; each cell claims, clears or measures its own slot as the search
// token passes.
// The result appears on status, slot, window_base, next_id and
// outstanding_mask for exactly one cycle, marked by done, once the command's
// token has passed tok0, every cell register and the result registers. The
// receiver cannot hold it off. Busy falls in the cycle done is high, and the
// next command can be transferred at the edge that ends that cycle, so a new
// command is not taken before the previous one has delivered its result.
// Synchronous reset empties every slot, sets the window base to 0 and the
// next expected id to 0, and clears busy and done.
module arq_send_window_top #(
  parameter int WINDOW_SLOTS = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic       operation,
  input  logic [7:0] packet_id,
  input  logic       frame_good,
  output logic       done,
  output logic [2:0] status,
  output logic [2:0] slot,
  output logic [7:0] window_base,
  output logic [7:0] next_id,
  output logic [7:0] outstanding_mask
);
  import arq_sw_pkg::*;

  logic [7:0]              left_edge;
  logic [7:0]              right_edge;
  logic [7:0]              left_edge_next;
  logic [7:0]              right_edge_next;
  token_t                  tok0;
  token_t                  chain [WINDOW_SLOTS + 1];
  token_t                  tok_end;
  logic [WINDOW_SLOTS-1:0] busy_vec;
  logic [7:0]              mask_all;
  status_t                 pre_status;
  status_t                 pre_status_next;
  status_t                 status_next;
  logic [2:0]              slot_next;
  logic [7:0]              count;
  logic                    accept;

  assign accept   = start && !busy;
  assign chain[0] = tok0;
  assign tok_end  = chain[WINDOW_SLOTS];

  for (genvar i = 0; i < WINDOW_SLOTS; i++) begin : g_cell
    arq_sw_cell #(
      .IDX(i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .tok_in    (chain[i]),
      .left_edge (left_edge),
      .tok_out   (chain[i+1]),
      .slot_busy (busy_vec[i])
    );
  end

  for (genvar b = 0; b < 8; b++) begin : g_mask
    if (b < WINDOW_SLOTS) begin : g_on
      assign mask_all[b] = busy_vec[b];
    end else begin : g_off
      assign mask_all[b] = 1'b0;
    end
  end

  always_comb begin
    count = right_edge - left_edge + 8'd1;
    if (count >= 8'(WINDOW_SLOTS)) begin
      pre_status_next = ST_FULL;
    end else if (!frame_good) begin
      pre_status_next = ST_BAD;
    end else if (packet_id != right_edge + 8'd1) begin
      pre_status_next = ST_SEQ;
    end else begin
      pre_status_next = ST_OK;
    end
  end

  always_comb begin
    left_edge_next  = left_edge;
    right_edge_next = right_edge;
    slot_next       = tok_end.found ? tok_end.slot : 3'd0;
    if (tok_end.ack) begin
      status_next = tok_end.found ? ST_OK : ST_NOACK;
      if (tok_end.found && (tok_end.id == left_edge)) begin
        left_edge_next = left_edge + tok_end.gap;
      end
    end else if (pre_status != ST_OK) begin
      status_next = pre_status;
    end else begin
      status_next = tok_end.found ? ST_OK : ST_FULL;
      if (tok_end.found) begin
        right_edge_next = right_edge + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      done       <= 1'b0;
      tok0       <= '0;
      left_edge  <= 8'd0;
      right_edge <= 8'd255;
    end else begin
      done       <= 1'b0;
      tok0.valid <= 1'b0;
      if (accept) begin
        busy       <= 1'b1;
        tok0.valid <= 1'b1;
        tok0.claim <= (operation == OP_ADD) && (pre_status_next == ST_OK);
        tok0.ack   <= (operation == OP_ACK);
        tok0.id    <= packet_id;
        tok0.found <= 1'b0;
        tok0.slot  <= 3'd0;
        tok0.gap   <= count;
        pre_status <= pre_status_next;
      end
      if (tok_end.valid) begin
        busy       <= 1'b0;
        done       <= 1'b1;
        left_edge  <= left_edge_next;
        right_edge <= right_edge_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tok_end.valid) begin
      status           <= status_next;
      slot             <= slot_next;
      window_base      <= left_edge_next;
      next_id          <= right_edge_next + 8'd1;
      outstanding_mask <= mask_all;
    end
  end

  a_done_idle : assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while a command is still in the chain");

  a_fell_done : assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $fell(busy) |-> done)
    else $error("command finished without a result transfer");

  a_start_busy : assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("command transfer did not raise busy");

  a_window_size : assert property (@(posedge clk) disable iff (rst)
    done |-> (8'(next_id - window_base) <= 8'(WINDOW_SLOTS)))
    else $error("window span exceeds the slot count");

endmodule
